@@ design/shb_pkg.sv @@
package shb_pkg;

   // Sizing of the buffer.
   localparam int SUPERSTRIP_BITS = 8;
   localparam int SUBSTRIP_BITS   = 4;
   localparam int HITS_PER_LIST   = 16;
   localparam int EVENT_SLOTS     = 4;

   // Derived widths and depths.
   localparam int SLOT_BITS       = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int USE_BITS        = $clog2(EVENT_SLOTS + 1);
   localparam int SUM_BITS        = USE_BITS + 1;
   localparam int HIT_BITS        = $clog2(HITS_PER_LIST + 1);
   localparam int HIT_IDX_BITS    = (HITS_PER_LIST > 1) ? $clog2(HITS_PER_LIST) : 1;
   localparam int LIST_ADDR_BITS  = SLOT_BITS + SUPERSTRIP_BITS;
   localparam int LIST_DEPTH      = 1 << LIST_ADDR_BITS;
   localparam int STORE_ADDR_BITS = LIST_ADDR_BITS + HIT_IDX_BITS;
   localparam int STORE_DEPTH     = 1 << STORE_ADDR_BITS;
   localparam int META_BITS       = HIT_BITS + 1;
   localparam int WORD_BITS       = SUPERSTRIP_BITS + SUBSTRIP_BITS;

   // Command codes.
   localparam logic [1:0] CMD_BEGIN   = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_LOOKUP  = 2'd2;
   localparam logic [1:0] CMD_RELEASE = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_HIT      = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_SLOT  = 2'd2;
   localparam logic [1:0] ST_NO_EVENT = 2'd3;

   typedef struct packed {
      logic [1:0]                 command;
      logic [SUPERSTRIP_BITS-1:0] superstrip;
      logic [SUBSTRIP_BITS-1:0]   substrip;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] hit_word;
      logic                 last_hit;
      logic [1:0]           status;
   } rsp_type;

endpackage

@@ design/shb_ram.sv @@
module shb_ram #(
   parameter int  WIDTH     = 8,
   parameter int  DEPTH     = 256,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/superstrip_hit_buffer_core.sv @@
// Release is done in the idle state; write reads the list entry and then appends the hit;
// begin sweeps all 2^SUPERSTRIP_BITS (256) entries of the new slot in the list memory, clearing
// its list counts and read marks. Lookup reads the list entry, then plays out each stored hit
// through the store memory's single registered read port; error results go out from S_EMIT.
// One command is worked at a time; a finished beat waits in the output register meanwhile.
// Reset clears the control state only; memories are not swept, as begin clears each slot.
module superstrip_hit_buffer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shb_pkg::req_type req_beat,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shb_pkg::rsp_type rsp_beat
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CLEAR   = 3'd1;
   localparam logic [2:0] S_WR_META = 3'd2;
   localparam logic [2:0] S_LK_META = 3'd3;
   localparam logic [2:0] S_LK_READ = 3'd4;
   localparam logic [2:0] S_LK_EMIT = 3'd5;
   localparam logic [2:0] S_EMIT    = 3'd6;

   logic [2:0]                           state_ff, state_in;
   logic [shb_pkg::SLOT_BITS-1:0]        oldest_ff, oldest_in;
   logic [shb_pkg::SLOT_BITS-1:0]        newest_ff, newest_in;
   logic [shb_pkg::USE_BITS-1:0]         used_ff, used_in;
   logic [shb_pkg::SUPERSTRIP_BITS-1:0]  ss_ff, ss_in;
   logic [shb_pkg::SUBSTRIP_BITS-1:0]    sub_ff, sub_in;
   logic [shb_pkg::SUPERSTRIP_BITS-1:0]  clr_ff, clr_in;
   logic [shb_pkg::HIT_BITS-1:0]         cnt_ff, cnt_in;
   logic [shb_pkg::HIT_BITS-1:0]         idx_ff, idx_in;
   logic [1:0]                           pend_ff, pend_in;
   logic                                 rsp_valid_ff;
   shb_pkg::rsp_type                     rsp_data_ff, rsp_data_in;
   logic                                 rsp_load;
   logic                                 rsp_free;
   logic                                 accept;
   logic                                 lk_last;

   logic                                 meta_wr_en;
   logic [shb_pkg::LIST_ADDR_BITS-1:0]   meta_wr_addr;
   logic [shb_pkg::META_BITS-1:0]        meta_wr_data;
   logic                                 meta_rd_en;
   logic [shb_pkg::LIST_ADDR_BITS-1:0]   meta_rd_addr;
   logic [shb_pkg::META_BITS-1:0]        meta_rd_data;
   logic [shb_pkg::HIT_BITS-1:0]         meta_count;
   logic                                 meta_mark;

   logic                                 store_wr_en;
   logic [shb_pkg::STORE_ADDR_BITS-1:0]  store_wr_addr;
   logic                                 store_rd_en;
   logic [shb_pkg::STORE_ADDR_BITS-1:0]  store_rd_addr;
   logic [shb_pkg::SUBSTRIP_BITS-1:0]    store_rd_data;

   // Slot index plus an offset, wrapped around the ring.
   function automatic logic [shb_pkg::SLOT_BITS-1:0] slot_add(
      input logic [shb_pkg::SLOT_BITS-1:0] base,
      input logic [shb_pkg::USE_BITS-1:0]  offset
   );
      logic [shb_pkg::SUM_BITS-1:0] sum;
      sum = shb_pkg::SUM_BITS'(base) + shb_pkg::SUM_BITS'(offset);
      if (sum >= shb_pkg::SUM_BITS'(shb_pkg::EVENT_SLOTS)) begin
         sum = sum - shb_pkg::SUM_BITS'(shb_pkg::EVENT_SLOTS);
      end
      return sum[shb_pkg::SLOT_BITS-1:0];
   endfunction

   // List memory: read mark on top of the hit count, one entry per slot and superstrip.
   shb_ram #(
      .WIDTH (shb_pkg::META_BITS),
      .DEPTH (shb_pkg::LIST_DEPTH)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_data)
   );

   // Substrip store: one entry per hit position of each list.
   shb_ram #(
      .WIDTH (shb_pkg::SUBSTRIP_BITS),
      .DEPTH (shb_pkg::STORE_DEPTH)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (sub_ff),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   assign meta_count = meta_rd_data[shb_pkg::HIT_BITS-1:0];
   assign meta_mark  = meta_rd_data[shb_pkg::META_BITS-1];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign lk_last   = (shb_pkg::HIT_BITS'(idx_ff + shb_pkg::HIT_BITS'(1)) == cnt_ff);

   // Command sequencer: write and lookup read a list entry, then may modify and write it back.
   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      newest_in     = newest_ff;
      used_in       = used_ff;
      ss_in         = ss_ff;
      sub_in        = sub_ff;
      clr_in        = clr_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      rsp_load      = 1'b0;
      rsp_data_in   = rsp_data_ff;
      meta_wr_en    = 1'b0;
      meta_wr_addr  = {newest_ff, clr_ff};
      meta_wr_data  = '0;
      meta_rd_en    = 1'b0;
      meta_rd_addr  = {newest_ff, req_beat.superstrip};
      store_wr_en   = 1'b0;
      store_wr_addr = {newest_ff, ss_ff, meta_count[shb_pkg::HIT_IDX_BITS-1:0]};
      store_rd_en   = 1'b0;
      store_rd_addr = {oldest_ff, ss_ff, idx_ff[shb_pkg::HIT_IDX_BITS-1:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ss_in  = req_beat.superstrip;
               sub_in = req_beat.substrip;
               priority if (req_beat.command == shb_pkg::CMD_BEGIN) begin
                  if (used_ff == shb_pkg::USE_BITS'(shb_pkg::EVENT_SLOTS)) begin
                     pend_in  = shb_pkg::ST_NO_SLOT;
                     state_in = S_EMIT;
                  end else begin
                     newest_in = slot_add(oldest_ff, used_ff);
                     used_in   = shb_pkg::USE_BITS'(used_ff + shb_pkg::USE_BITS'(1));
                     clr_in    = '0;
                     state_in  = S_CLEAR;
                  end
               end else if (used_ff == '0) begin
                  pend_in  = shb_pkg::ST_NO_EVENT;
                  state_in = S_EMIT;
               end else begin
                  unique case (req_beat.command)
                     shb_pkg::CMD_WRITE: begin
                        meta_rd_en   = 1'b1;
                        meta_rd_addr = {newest_ff, req_beat.superstrip};
                        state_in     = S_WR_META;
                     end
                     shb_pkg::CMD_LOOKUP: begin
                        meta_rd_en   = 1'b1;
                        meta_rd_addr = {oldest_ff, req_beat.superstrip};
                        state_in     = S_LK_META;
                     end
                     shb_pkg::CMD_RELEASE: begin
                        oldest_in = slot_add(oldest_ff, shb_pkg::USE_BITS'(1));
                        used_in   = shb_pkg::USE_BITS'(used_ff - shb_pkg::USE_BITS'(1));
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end

         // Sweep the new slot's lists, one entry a cycle.
         S_CLEAR: begin
            meta_wr_en   = 1'b1;
            meta_wr_addr = {newest_ff, clr_ff};
            meta_wr_data = '0;
            clr_in       = clr_ff + shb_pkg::SUPERSTRIP_BITS'(1);
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         // Append the hit unless the list is full.
         S_WR_META: begin
            if (meta_count >= shb_pkg::HIT_BITS'(shb_pkg::HITS_PER_LIST)) begin
               pend_in  = shb_pkg::ST_FULL;
               state_in = S_EMIT;
            end else begin
               store_wr_en   = 1'b1;
               store_wr_addr = {newest_ff, ss_ff, meta_count[shb_pkg::HIT_IDX_BITS-1:0]};
               meta_wr_en    = 1'b1;
               meta_wr_addr  = {newest_ff, ss_ff};
               meta_wr_data  = {1'b0, shb_pkg::HIT_BITS'(meta_count + shb_pkg::HIT_BITS'(1))};
               state_in      = S_IDLE;
            end
         end

         // An unread, non-empty list is marked read and then played out.
         S_LK_META: begin
            if (meta_count == '0 || meta_mark) begin
               state_in = S_IDLE;
            end else begin
               meta_wr_en   = 1'b1;
               meta_wr_addr = {oldest_ff, ss_ff};
               meta_wr_data = {1'b1, meta_count};
               cnt_in       = meta_count;
               idx_in       = '0;
               state_in     = S_LK_READ;
            end
         end

         S_LK_READ: begin
            store_rd_en   = 1'b1;
            store_rd_addr = {oldest_ff, ss_ff, idx_ff[shb_pkg::HIT_IDX_BITS-1:0]};
            state_in      = S_LK_EMIT;
         end

         S_LK_EMIT: begin
            if (rsp_free) begin
               rsp_load             = 1'b1;
               rsp_data_in.hit_word = {ss_ff, store_rd_data};
               rsp_data_in.last_hit = lk_last;
               rsp_data_in.status   = shb_pkg::ST_HIT;
               idx_in               = shb_pkg::HIT_BITS'(idx_ff + shb_pkg::HIT_BITS'(1));
               state_in             = lk_last ? S_IDLE : S_LK_READ;
            end
         end

         // Single error beat; a dropped hit carries its own word.
         S_EMIT: begin
            if (rsp_free) begin
               rsp_load             = 1'b1;
               rsp_data_in.hit_word = (pend_ff == shb_pkg::ST_FULL) ? {ss_ff, sub_ff} : '0;
               rsp_data_in.last_hit = 1'b1;
               rsp_data_in.status   = pend_ff;
               state_in             = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         newest_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         used_ff   <= used_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the current command and the output beat.
   always_ff @(posedge clock) begin
      ss_ff   <= ss_in;
      sub_ff  <= sub_in;
      clr_ff  <= clr_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      pend_ff <= pend_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_data_ff;

   // The ring never holds more events than it has slots.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= shb_pkg::USE_BITS'(shb_pkg::EVENT_SLOTS))
      else $error("slot occupancy beyond ring size");

   // A slot is only swept after it has been counted as in use.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> used_ff != '0)
      else $error("clear sweep with no slot open");

   // Playback never runs past the list length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LK_READ || state_ff == S_LK_EMIT) |-> idx_ff < cnt_ff)
      else $error("lookup index beyond list count");

   // A beat is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("output beat overwritten");

   // An accepted release frees exactly one slot.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_beat.command == shb_pkg::CMD_RELEASE && used_ff != '0
      |=> used_ff == shb_pkg::USE_BITS'($past(used_ff) - shb_pkg::USE_BITS'(1)))
      else $error("release did not free one slot");

endmodule

@@ tb/tb.sv @@
module tb;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int MAX_IDLE      = 12;
   localparam int SETTLE_CYCLES = 300;
   localparam int REPORT_CAP    = 10;
   localparam int SS_TOP        = (1 << shb_pkg::SUPERSTRIP_BITS) - 1;
   localparam int SUB_TOP       = (1 << shb_pkg::SUBSTRIP_BITS) - 1;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   shb_pkg::req_type req_beat  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   shb_pkg::rsp_type rsp_beat;

   // Mirror of the layer buffer: per-list fill levels, read marks and stored substrips.
   logic [shb_pkg::HIT_BITS-1:0]      fill_level   [shb_pkg::LIST_DEPTH];
   logic                              already_read [shb_pkg::LIST_DEPTH];
   logic [shb_pkg::SUBSTRIP_BITS-1:0] hit_store    [shb_pkg::STORE_DEPTH];
   int oldest_event = 0;
   int newest_event = 0;
   int events_open  = 0;

   shb_pkg::rsp_type awaited_words [$];
   int      fault_count = 0;
   int      reported    = 0;
   int      cycle_count = 0;
   int      beats_sent  = 0;
   // While set, neither side idles.
   bit      steady      = 1'b0;

   superstrip_hit_buffer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int idle_draw();
      return steady ? 0 : int'($urandom_range(0, MAX_IDLE));
   endfunction

   // Random field values at the width of their fields.
   function automatic logic [shb_pkg::SUPERSTRIP_BITS-1:0] pick_ss();
      return shb_pkg::SUPERSTRIP_BITS'($urandom_range(0, SS_TOP));
   endfunction

   function automatic logic [shb_pkg::SUBSTRIP_BITS-1:0] pick_sub();
      return shb_pkg::SUBSTRIP_BITS'($urandom_range(0, SUB_TOP));
   endfunction

   function automatic logic [1:0] pick_cmd();
      return 2'($urandom_range(0, 3));
   endfunction

   function automatic void await_word(logic [shb_pkg::WORD_BITS-1:0] word, logic last,
                                      logic [1:0] status);
      shb_pkg::rsp_type w;
      w.hit_word = word;
      w.last_hit = last;
      w.status   = status;
      awaited_words = {awaited_words, w};
   endfunction

   // Applies one accepted command to the mirror and queues the hit words it yields.
   function automatic void mirror_command(shb_pkg::req_type b);
      logic [shb_pkg::LIST_ADDR_BITS-1:0] list;
      int fill;
      if (b.command == shb_pkg::CMD_BEGIN) begin
         if (events_open >= shb_pkg::EVENT_SLOTS) begin
            await_word('0, 1'b1, shb_pkg::ST_NO_SLOT);
         end else begin
            newest_event = (oldest_event + events_open) % shb_pkg::EVENT_SLOTS;
            for (int s = 0; s <= SS_TOP; s++) begin
               list = {newest_event[shb_pkg::SLOT_BITS-1:0],
                       s[shb_pkg::SUPERSTRIP_BITS-1:0]};
               fill_level[list]   = '0;
               already_read[list] = 1'b0;
            end
            events_open++;
         end
      end else if (events_open == 0) begin
         await_word('0, 1'b1, shb_pkg::ST_NO_EVENT);
      end else if (b.command == shb_pkg::CMD_RELEASE) begin
         oldest_event = (oldest_event + 1) % shb_pkg::EVENT_SLOTS;
         events_open--;
      end else if (b.command == shb_pkg::CMD_WRITE) begin
         list = {newest_event[shb_pkg::SLOT_BITS-1:0], b.superstrip};
         fill = int'(fill_level[list]);
         if (fill >= shb_pkg::HITS_PER_LIST) begin
            await_word({b.superstrip, b.substrip}, 1'b1, shb_pkg::ST_FULL);
         end else begin
            hit_store[{list, fill[shb_pkg::HIT_IDX_BITS-1:0]}] = b.substrip;
            fill_level[list]   = shb_pkg::HIT_BITS'(fill + 1);
            already_read[list] = 1'b0;
         end
      end else begin
         // A lookup reads the oldest event, once per list until it is written again.
         list = {oldest_event[shb_pkg::SLOT_BITS-1:0], b.superstrip};
         fill = int'(fill_level[list]);
         if (fill > shb_pkg::HITS_PER_LIST) fill = shb_pkg::HITS_PER_LIST;
         if (fill != 0 && !already_read[list]) begin
            for (int i = 0; i < fill; i++) begin
               await_word({b.superstrip, hit_store[{list, i[shb_pkg::HIT_IDX_BITS-1:0]}]},
                          i == fill - 1, shb_pkg::ST_HIT);
            end
            already_read[list] = 1'b1;
         end
      end
   endfunction

   function automatic void log_fault(bit have_want, shb_pkg::rsp_type want,
                                     shb_pkg::rsp_type got);
      fault_count++;
      if (reported < REPORT_CAP) begin
         reported++;
         if (have_want) begin
            $display("Mismatch: expected word %h last %b status %0d, %s %h last %b status %0d",
                     want.hit_word, want.last_hit, want.status, "got word",
                     got.hit_word, got.last_hit, got.status);
         end else begin
            $display("Unexpected beat: word %h last %b status %0d",
                     got.hit_word, got.last_hit, got.status);
         end
      end
   endfunction

   // Sends one command beat after a random gap and updates the mirror once it is taken.
   task automatic send_beat(logic [1:0] command,
                            logic [shb_pkg::SUPERSTRIP_BITS-1:0] superstrip,
                            logic [shb_pkg::SUBSTRIP_BITS-1:0] substrip);
      int               gap;
      shb_pkg::req_type item;
      item.command    = command;
      item.superstrip = superstrip;
      item.substrip   = substrip;
      gap = idle_draw();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat  <= item;
      do @(posedge clock); while (req_stall);
      mirror_command(item);
      beats_sent++;
   endtask

   // Holds the sender off until every awaited hit word has come out.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_without_event();
      // Every command but begin needs an open event.
      send_beat(shb_pkg::CMD_WRITE, '1, '1);
      send_beat(shb_pkg::CMD_LOOKUP, '0, '0);
      send_beat(shb_pkg::CMD_RELEASE, '1, '0);
   endtask

   task automatic test_ring_full();
      repeat (shb_pkg::EVENT_SLOTS) send_beat(shb_pkg::CMD_BEGIN, pick_ss(), '0);
      // No slot is left for a further event.
      send_beat(shb_pkg::CMD_BEGIN, '0, '1);
      // Writes go to the newest event while lookups read the oldest one.
      send_beat(shb_pkg::CMD_WRITE, 8'h3C, 4'h9);
      send_beat(shb_pkg::CMD_LOOKUP, 8'h3C, '0);
      repeat (shb_pkg::EVENT_SLOTS - 1) send_beat(shb_pkg::CMD_RELEASE, '0, '0);
      send_beat(shb_pkg::CMD_LOOKUP, 8'h3C, '0);
      send_beat(shb_pkg::CMD_RELEASE, '0, '0);
   endtask

   task automatic test_field_extremes();
      send_beat(shb_pkg::CMD_BEGIN, '0, '0);
      send_beat(shb_pkg::CMD_WRITE, '0, '0);
      send_beat(shb_pkg::CMD_WRITE, '1, '1);
      send_beat(shb_pkg::CMD_WRITE, '1, '0);
      send_beat(shb_pkg::CMD_LOOKUP, '0, '0);
      send_beat(shb_pkg::CMD_LOOKUP, '1, '0);
      // A list already read and an empty list give nothing.
      send_beat(shb_pkg::CMD_LOOKUP, '1, '1);
      send_beat(shb_pkg::CMD_LOOKUP, 8'h5A, '0);
      // A new write marks the list unread again, so the whole list comes back.
      send_beat(shb_pkg::CMD_WRITE, '1, 4'h5);
      send_beat(shb_pkg::CMD_LOOKUP, '1, '0);
   endtask

   task automatic test_full_list();
      // The list for superstrip zero already holds one hit.
      for (int i = 1; i < shb_pkg::HITS_PER_LIST; i++)
         send_beat(shb_pkg::CMD_WRITE, '0, i[shb_pkg::SUBSTRIP_BITS-1:0]);
      send_beat(shb_pkg::CMD_WRITE, '0, 4'hC);
      send_beat(shb_pkg::CMD_LOOKUP, '0, '0);
      send_beat(shb_pkg::CMD_RELEASE, '0, '0);
   endtask

   // Mostly whole events with random hits, read back and freed, with some noise between.
   task automatic test_random_traffic(int beats);
      logic [shb_pkg::SUPERSTRIP_BITS-1:0] picks [3];
      int target;
      int n_picks;
      target = beats_sent + beats;
      while (beats_sent < target) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 8) begin
            if (events_open > 1 && $urandom_range(0, 1) == 1)
               send_beat(shb_pkg::CMD_RELEASE, pick_ss(), pick_sub());
            if (events_open == 0 || $urandom_range(0, 1) == 1)
               send_beat(shb_pkg::CMD_BEGIN, pick_ss(), pick_sub());
            n_picks = int'($urandom_range(1, 3));
            for (int i = 0; i < 3; i++) picks[i] = pick_ss();
            repeat ($urandom_range(1, 20)) begin
               send_beat(shb_pkg::CMD_WRITE, picks[$urandom_range(0, n_picks - 1)],
                         pick_sub());
            end
            // Bring the written event to the front now and then so lookups find it.
            while (events_open > 1 && $urandom_range(0, 2) != 0)
               send_beat(shb_pkg::CMD_RELEASE, pick_ss(), pick_sub());
            for (int i = 0; i < n_picks; i++)
               send_beat(shb_pkg::CMD_LOOKUP, picks[i], pick_sub());
            if ($urandom_range(0, 1) == 1)
               send_beat(shb_pkg::CMD_LOOKUP, pick_ss(), pick_sub());
            if ($urandom_range(0, 3) == 0)
               send_beat(shb_pkg::CMD_RELEASE, pick_ss(), pick_sub());
         end else begin
            repeat ($urandom_range(1, 4)) begin
               send_beat(pick_cmd(), pick_ss(), pick_sub());
            end
         end
      end
      steady = 1'b0;
   endtask

   // Result side: random stalls after each beat, and a check of every beat taken.
   initial begin
      int               hold;
      shb_pkg::rsp_type got;
      shb_pkg::rsp_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            got = rsp_beat;
            if (awaited_words.size() == 0) begin
               log_fault(1'b0, '0, got);
            end else begin
               want = awaited_words.pop_front();
               if (got.hit_word !== want.hit_word || got.last_hit !== want.last_hit ||
                   got.status !== want.status) begin
                  log_fault(1'b1, want, got);
               end
            end
            hold = idle_draw();
         end else if (hold > 0) begin
            hold--;
         end
         rsp_stall <= (hold > 0);
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      for (int i = 0; i < shb_pkg::LIST_DEPTH; i++) begin
         fill_level[i]   = '0;
         already_read[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_without_event();
      test_ring_full();
      test_field_extremes();
      test_full_list();
      wait_for_results();
      test_random_traffic(130);
      wait_for_results();
      test_random_traffic(130);

      // Drain, then give any stray beat time to show up.
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_words.size() != 0) begin
         fault_count++;
         $display("%0d expected hit words never arrived", awaited_words.size());
      end
      if (fault_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/shb_pkg.sv
design/shb_ram.sv
design/superstrip_hit_buffer_core.sv
tb/tb.sv
